// ===== hw/rtl/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// kmp_pkg: shared types and constants for the k-transaction profit engine
// Widths, the minus-infinity cash sentinel, the chain link record and the
// saturating cash arithmetic used by every cell.
// ----------------------------------------------------------------------------
package kmp_pkg;

  localparam int MAX_TRANS_DEF = 16;
  localparam int CFG_W         = 5;
  localparam int PRICE_W       = 16;
  localparam int PROFIT_W      = 31;
  localparam int CASH_W        = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd2;

  typedef logic signed [CASH_W-1:0]  cash_t;
  typedef logic signed [PRICE_W:0]   delta_t;

  // most negative value marks an unreachable entry
  localparam cash_t CASH_NEG_INF = 32'sh8000_0000;
  localparam cash_t CASH_MAX     = 32'sh7FFF_FFFF;
  localparam cash_t CASH_MIN     = 32'sh8000_0001;

  // what one cell hands to the next
  typedef struct packed {
    logic                valid;
    logic [PRICE_W-1:0]  price;
    logic                first_day;
    cash_t               nh_old;   // sender's not-holding value from the previous day
    logic [PROFIT_W-1:0] best;     // running maximum of included not-holding values
  } kmp_link_t;

  // sentinel is sticky; everything else clamps to +/-(2^31-1)
  function automatic cash_t cash_add_sat(cash_t a, delta_t d);
    logic signed [CASH_W:0] s;
    cash_t                  res;
    s = (CASH_W+1)'(a) + (CASH_W+1)'(d);
    if (a == CASH_NEG_INF) begin
      res = CASH_NEG_INF;
    end else if (s > (CASH_W+1)'(CASH_MAX)) begin
      res = CASH_MAX;
    end else if (s < (CASH_W+1)'(CASH_MIN)) begin
      res = CASH_MIN;
    end else begin
      res = s[CASH_W-1:0];
    end
    return res;
  endfunction

  function automatic cash_t cash_max(cash_t a, cash_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== hw/rtl/kmp_in_if.sv =====
// ----------------------------------------------------------------------------
// kmp_in_if: price stream channel
// One transfer carries one day's price and the start-of-series flag.
// ----------------------------------------------------------------------------
interface kmp_in_if;
  logic                         valid;
  logic                         ready;
  logic [kmp_pkg::PRICE_W-1:0]  price;
  logic                         first_day;

  modport source (output valid, price, first_day, input ready);
  modport sink   (input valid, price, first_day, output ready);
endinterface

// ===== hw/rtl/kmp_out_if.sv =====
// ----------------------------------------------------------------------------
// kmp_out_if: profit result channel
// One transfer carries the best profit after one day.
// ----------------------------------------------------------------------------
interface kmp_out_if;
  logic                          valid;
  logic                          ready;
  logic [kmp_pkg::PROFIT_W-1:0]  best_profit;

  modport source (output valid, best_profit, input ready);
  modport sink   (input valid, best_profit, output ready);
endinterface

// ===== hw/rtl/kmp_cell.sv =====
// ----------------------------------------------------------------------------
// kmp_cell: one transaction-count entry of the profit chain
// Holds not-holding / holding cash for count CELL_IDX, updates it when a day
// passes by, and forwards the day plus its old not-holding value downstream.
// ----------------------------------------------------------------------------
module kmp_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic [kmp_pkg::CFG_W-1:0]      k,
  input  kmp_pkg::kmp_link_t             link_i,
  output kmp_pkg::kmp_link_t             link_o
);
  import kmp_pkg::*;

  cash_t               nh_r, nh_nxt;
  cash_t               h_r, h_nxt;
  logic                valid_r;
  logic [PRICE_W-1:0]  price_r;
  logic                first_r;
  cash_t               nh_old_r;
  logic [PROFIT_W-1:0] best_r, best_nxt;
  delta_t              d_pos, d_neg;
  logic                incl;

  assign d_pos = $signed({1'b0, link_i.price});
  assign d_neg = -d_pos;
  assign incl  = (k != '0) && (32'(CELL_IDX) <= 32'(k));

  always_comb begin
    if (link_i.first_day) begin
      nh_nxt = (CELL_IDX == 0) ? cash_t'(0) : CASH_NEG_INF;
      h_nxt  = (CELL_IDX == 1) ? cash_t'(d_neg) : CASH_NEG_INF;
    end else begin
      nh_nxt = cash_max(nh_r, cash_add_sat(h_r, d_pos));
      h_nxt  = cash_max(h_r, cash_add_sat(link_i.nh_old, d_neg));
    end
    best_nxt = link_i.best;
    if (incl && (nh_nxt > $signed({1'b0, link_i.best}))) begin
      best_nxt = nh_nxt[PROFIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      nh_r    <= CASH_NEG_INF;
      h_r     <= CASH_NEG_INF;
    end else if (adv) begin
      valid_r <= link_i.valid;
      if (link_i.valid) begin
        nh_r <= nh_nxt;
        h_r  <= h_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && link_i.valid) begin
      price_r  <= link_i.price;
      first_r  <= link_i.first_day;
      nh_old_r <= nh_r;
      best_r   <= best_nxt;
    end
  end

  assign link_o = '{valid: valid_r, price: price_r, first_day: first_r,
                    nh_old: nh_old_r, best: best_r};

endmodule

// ===== hw/rtl/k_transaction_max_profit_dp.sv =====
// ----------------------------------------------------------------------------
// k_transaction_max_profit_dp: best profit with at most k buy/sell transactions
// Daily prices stream in, one per transfer; first_day starts a new series.
// The block takes one price per cycle while its output is not stalled and
// returns one best_profit per price. Each day walks down the row of cells,
// one cell (one transaction count) per cycle while the row advances, and is
// registered in each, so consecutive days overlap in the row.
// The cfg register (max_transactions, reset 2) may only be written while no
// day is in flight; values above MAX_TRANSACTIONS act as MAX_TRANSACTIONS and
// zero forces a result of 0. Results are saturated and never negative.
// ----------------------------------------------------------------------------
//
// Chain notes:
//  - cell j owns not-holding[j] and holding[j]. A day reaches cell j through
//    the link register of cell j-1, so cell j-1 forwards its pre-update
//    not-holding value with the day; that is exactly the previous day's value
//    j needs for the buy term.
//  - the running best rides along the chain; cells beyond the limit pass it
//    through untouched.
//  - the last cell's registers are the output register. The whole row moves
//    together and freezes when that result is not taken.
//  - before any first_day every entry is the sentinel, so such days give 0.
module k_transaction_max_profit_dp #(
  parameter int MAX_TRANSACTIONS = kmp_pkg::MAX_TRANS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  kmp_in_if.sink                     in_ch,
  kmp_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [kmp_pkg::CFG_W-1:0]  cfg_wdata
);
  import kmp_pkg::*;

  localparam int DEPTH = MAX_TRANSACTIONS + 1;

  logic [CFG_W-1:0] k_r;
  logic             adv;
  kmp_link_t        link [0:DEPTH];

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= CFG_RESET;
    end else if (cfg_we) begin
      k_r <= cfg_wdata;
    end
  end

  // global advance: hold every stage while a finished result waits
  assign adv         = !(out_ch.valid && !out_ch.ready);
  assign in_ch.ready = adv;

  // head of the chain: no lower count exists, so the buy term sees the sentinel
  assign link[0] = '{valid: in_ch.valid, price: in_ch.price,
                     first_day: in_ch.first_day, nh_old: CASH_NEG_INF, best: '0};

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    kmp_cell #(
      .CELL_IDX (j)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .k      (k_r),
      .link_i (link[j]),
      .link_o (link[j+1])
    );
  end

  assign out_ch.valid       = link[DEPTH].valid;
  assign out_ch.best_profit = link[DEPTH].best;

endmodule
